[design/dual_wheel_ramped_pd_speed_control_macros.svh]
// assertion macros used by the checker file
`ifndef DUAL_WHEEL_RAMPED_PD_SPEED_CONTROL_MACROS_SVH
`define DUAL_WHEEL_RAMPED_PD_SPEED_CONTROL_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define DWRPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define DWRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/dwrpd_pkg.sv]
// types and constants of the dual wheel ramped pd speed controller
package dwrpd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN_RIGHT = 3'd5;

    localparam logic [7:0]  ACCEL_STEP_RST = 8'd2;
    localparam logic [7:0]  DECEL_STEP_RST = 8'd3;
    localparam logic [15:0] PROP_GAIN_RST  = 16'd20;
    localparam logic [15:0] DERIV_GAIN_RST = 16'd100;

    // per wheel data after the state update
    typedef struct packed {
        logic signed [15:0] ramp;
        logic signed [31:0] err;
        logic signed [32:0] diff;
        logic        [31:0] total;
    } wheel_s1_t;

    // pipeline stage enables
    typedef struct packed {
        logic en2;
        logic en3;
    } pipe_ctl_t;

endpackage

[design/dwrpd_tick_if.sv]
// input channel: encoder counts and target speeds for one tick
interface dwrpd_tick_if;
    logic               valid;
    logic               ready;
    logic        [31:0] left_counter;
    logic        [31:0] right_counter;
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;

    modport source (
        output valid, left_counter, right_counter, target_left, target_right,
        input  ready
    );
    modport sink (
        input  valid, left_counter, right_counter, target_left, target_right,
        output ready
    );
endinterface

[design/dwrpd_result_if.sv]
// output channel: drives, ramped speeds and distance for one tick
interface dwrpd_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
    logic signed [31:0] distance;

    modport source (
        output valid, drive_left, drive_right, speed_left, speed_right, distance,
        input  ready
    );
    modport sink (
        input  valid, drive_left, drive_right, speed_left, speed_right, distance,
        output ready
    );
endinterface

[design/dwrpd_wheel.sv]
// per wheel state: count delta, running total, speed ramp and error accumulator
module dwrpd_wheel (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic            [31:0] counter,
    input  logic signed     [15:0] target,
    input  logic            [7:0]  accel_step,
    input  logic            [7:0]  decel_step,
    output dwrpd_pkg::wheel_s1_t   s1
);

    logic        [31:0] last_reg;
    logic        [31:0] total_reg;
    logic signed [15:0] ramp_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] diff_reg;

    logic        [31:0] delta;
    logic signed [17:0] cur;
    logic signed [17:0] tgt;
    logic signed [17:0] acc;
    logic signed [17:0] dec;
    logic signed [17:0] step;
    logic signed [15:0] ramp_next;
    logic signed [33:0] err_sum;
    logic signed [31:0] err_next;
    logic signed [32:0] diff_next;

    assign delta = counter - last_reg;
    assign cur   = {{2{ramp_reg[15]}}, ramp_reg};
    assign tgt   = {{2{target[15]}}, target};
    assign acc   = $signed({10'd0, accel_step});
    assign dec   = $signed({10'd0, decel_step});

    always_comb
    begin
        step      = cur;
        ramp_next = ramp_reg;
        if (cur < tgt && !cur[17])
        begin
            step      = cur + acc;
            ramp_next = (step > tgt) ? target : step[15:0];
        end
        else if (cur > tgt && cur > 18'sd0)
        begin
            step      = cur - dec;
            ramp_next = (step < tgt) ? target : step[15:0];
        end
        else if (cur < tgt && cur[17])
        begin
            step      = cur + dec;
            ramp_next = (step > tgt) ? target : step[15:0];
        end
        else if (cur > tgt && tgt <= 18'sd0)
        begin
            step      = cur - acc;
            ramp_next = (step < tgt) ? target : step[15:0];
        end
    end

    // error accumulates speed minus delta, saturating at 32 bits
    always_comb
    begin
        err_sum = {{2{err_reg[31]}}, err_reg} + {{18{ramp_next[15]}}, ramp_next}
                - {{2{delta[31]}}, delta};
        if (err_sum[33:31] == 3'b000 || err_sum[33:31] == 3'b111)
        begin
            err_next = err_sum[31:0];
        end
        else if (err_sum[33])
        begin
            err_next = {1'b1, 31'd0};
        end
        else
        begin
            err_next = {1'b0, {31{1'b1}}};
        end
        diff_next = {err_next[31], err_next} - {err_reg[31], err_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            total_reg <= '0;
            ramp_reg  <= '0;
            err_reg   <= '0;
        end
        else if (accept)
        begin
            last_reg  <= counter;
            total_reg <= total_reg + delta;
            ramp_reg  <= ramp_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg <= diff_next;
        end
    end

    assign s1.ramp  = ramp_reg;
    assign s1.err   = err_reg;
    assign s1.diff  = diff_reg;
    assign s1.total = total_reg;

endmodule

[design/dwrpd_pd.sv]
// pd drive: registered gain products, then sum and 16-bit saturation
module dwrpd_pd (
    input  logic                   clk,
    input  dwrpd_pkg::pipe_ctl_t   ctl,
    input  dwrpd_pkg::wheel_s1_t   s1,
    input  logic            [15:0] prop_gain,
    input  logic            [15:0] deriv_gain,
    output logic signed     [15:0] drive,
    output logic signed     [15:0] speed
);

    logic signed [48:0] prop_reg;
    logic signed [49:0] deriv_reg;
    logic signed [15:0] ramp2_reg;
    logic signed [15:0] drive_reg;
    logic signed [15:0] speed_reg;

    logic signed [48:0] prop_next;
    logic signed [49:0] deriv_next;
    logic signed [50:0] sum;
    logic signed [15:0] drive_next;

    assign prop_next  = $signed({1'b0, prop_gain}) * s1.err;
    assign deriv_next = $signed({1'b0, deriv_gain}) * s1.diff;

    always_comb
    begin
        sum = {{2{prop_reg[48]}}, prop_reg} + {deriv_reg[49], deriv_reg};
        if (sum > 51'sd32767)
        begin
            drive_next = 16'sh7fff;
        end
        else if (sum < -51'sd32768)
        begin
            drive_next = 16'sh8000;
        end
        else
        begin
            drive_next = sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            prop_reg  <= prop_next;
            deriv_reg <= deriv_next;
            ramp2_reg <= s1.ramp;
        end
        if (ctl.en3)
        begin
            drive_reg <= drive_next;
            speed_reg <= ramp2_reg;
        end
    end

    assign drive = drive_reg;
    assign speed = speed_reg;

endmodule

[design/dual_wheel_ramped_pd_speed_control.sv]
// top level of the dual wheel ramped pd speed controller
//
// channel  | dir | beat contents
// tick     | in  | left_counter, right_counter, target_left, target_right
// result   | out | drive_left, drive_right, speed_left, speed_right, distance
// cfg      | in  | cfg_we, cfg_index, cfg_data
//
// one tick per cycle sustained while the result sink keeps ready; a result passes the wheel, gain and drive registers
// wheel state updates on acceptance, then gain multiply, then sum and saturate
// each stage holds on its own when the next is full, so bubbles close up
// reset clears wheel state, stage valids and loads the default gains and steps
module dual_wheel_ramped_pd_speed_control (
    input  logic                                 clk,
    input  logic                                 rst_n,
    dwrpd_tick_if.sink                           tick,
    dwrpd_result_if.source                       result,
    input  logic                                 cfg_we,
    input  logic [dwrpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwrpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic        [7:0]  accel_step_reg;
    logic        [7:0]  decel_step_reg;
    logic        [15:0] prop_gain_left_reg;
    logic        [15:0] deriv_gain_left_reg;
    logic        [15:0] prop_gain_right_reg;
    logic        [15:0] deriv_gain_right_reg;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic signed [31:0] dist2_reg;
    logic signed [31:0] dist3_reg;

    logic               en1;
    logic               accept;
    logic signed [32:0] total_sum;
    logic signed [32:0] total_adj;
    dwrpd_pkg::pipe_ctl_t ctl;
    dwrpd_pkg::wheel_s1_t s1_left;
    dwrpd_pkg::wheel_s1_t s1_right;

    assign ctl.en3    = !v3_reg || result.ready;
    assign ctl.en2    = !v2_reg || ctl.en3;
    assign en1        = !v1_reg || ctl.en2;
    assign tick.ready = en1;
    assign accept     = tick.valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_step_reg       <= dwrpd_pkg::ACCEL_STEP_RST;
            decel_step_reg       <= dwrpd_pkg::DECEL_STEP_RST;
            prop_gain_left_reg   <= dwrpd_pkg::PROP_GAIN_RST;
            deriv_gain_left_reg  <= dwrpd_pkg::DERIV_GAIN_RST;
            prop_gain_right_reg  <= dwrpd_pkg::PROP_GAIN_RST;
            deriv_gain_right_reg <= dwrpd_pkg::DERIV_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dwrpd_pkg::CFG_ACCEL_STEP:       accel_step_reg       <= cfg_data[7:0];
                dwrpd_pkg::CFG_DECEL_STEP:       decel_step_reg       <= cfg_data[7:0];
                dwrpd_pkg::CFG_PROP_GAIN_LEFT:   prop_gain_left_reg   <= cfg_data;
                dwrpd_pkg::CFG_DERIV_GAIN_LEFT:  deriv_gain_left_reg  <= cfg_data;
                dwrpd_pkg::CFG_PROP_GAIN_RIGHT:  prop_gain_right_reg  <= cfg_data;
                dwrpd_pkg::CFG_DERIV_GAIN_RIGHT: deriv_gain_right_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= accept;
            end
            if (ctl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctl.en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    dwrpd_wheel u_wheel_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .counter    (tick.left_counter),
        .target     (tick.target_left),
        .accel_step (accel_step_reg),
        .decel_step (decel_step_reg),
        .s1         (s1_left)
    );

    dwrpd_wheel u_wheel_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .counter    (tick.right_counter),
        .target     (tick.target_right),
        .accel_step (accel_step_reg),
        .decel_step (decel_step_reg),
        .s1         (s1_right)
    );

    dwrpd_pd u_pd_left (
        .clk        (clk),
        .ctl        (ctl),
        .s1         (s1_left),
        .prop_gain  (prop_gain_left_reg),
        .deriv_gain (deriv_gain_left_reg),
        .drive      (result.drive_left),
        .speed      (result.speed_left)
    );

    dwrpd_pd u_pd_right (
        .clk        (clk),
        .ctl        (ctl),
        .s1         (s1_right),
        .prop_gain  (prop_gain_right_reg),
        .deriv_gain (deriv_gain_right_reg),
        .drive      (result.drive_right),
        .speed      (result.speed_right)
    );

    // average of both totals, rounded toward zero
    assign total_sum = {s1_left.total[31], s1_left.total}
                     + {s1_right.total[31], s1_right.total};
    assign total_adj = total_sum + {32'd0, total_sum[32]};

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            dist2_reg <= total_adj[32:1];
        end
        if (ctl.en3)
        begin
            dist3_reg <= dist2_reg;
        end
    end

    assign result.valid    = v3_reg;
    assign result.distance = dist3_reg;

endmodule

[design/dwrpd_checker.sv]
// port-level checks of the speed controller and their binding
`include "dual_wheel_ramped_pd_speed_control_macros.svh"

module dwrpd_checker (
    input logic clk,
    input logic rst_n,
    input logic tick_valid,
    input logic tick_ready,
    input logic result_valid,
    input logic result_ready
);

    // a waiting result beat stays offered
    `DWRPD_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)

    // with the output free the pipeline always takes a tick
    `DWRPD_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !result_valid || result_ready, tick_ready)

    // a tick reaches the output through the wheel, gain and drive registers when the sink keeps up
    `DWRPD_ASSERT_SAME(a_latency, clk, rst_n, tick_valid && tick_ready ##1 result_ready ##1 result_ready, ##1 result_valid)

endmodule

bind dual_wheel_ramped_pd_speed_control dwrpd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick.valid),
    .tick_ready   (tick.ready),
    .result_valid (result.valid),
    .result_ready (result.ready)
);

[test/tb.sv]
// testbench for the dual wheel ramped pd speed controller: directed and random ticks
module tb;

    localparam logic [dwrpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [dwrpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam longint ERR_MAX   = 64'sd2147483647;
    localparam longint ERR_MIN   = -64'sd2147483648;
    localparam longint DRIVE_MAX = 64'sd32767;
    localparam longint DRIVE_MIN = -64'sd32768;

    typedef struct {
        logic        [31:0] left_counter;
        logic        [31:0] right_counter;
        logic signed [15:0] target_left;
        logic signed [15:0] target_right;
    } tick_t;

    typedef struct {
        logic signed [15:0] drive_left;
        logic signed [15:0] drive_right;
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
        logic signed [31:0] distance;
    } control_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [dwrpd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dwrpd_pkg::CFG_DATA_W-1:0] cfg_data;

    dwrpd_tick_if   tick_bus();
    dwrpd_result_if result_bus();

    dual_wheel_ramped_pd_speed_control u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller model: configuration and wheel state
    logic [7:0]  accel_q;
    logic [7:0]  decel_q;
    logic [15:0] kp_l;
    logic [15:0] kd_l;
    logic [15:0] kp_r;
    logic [15:0] kd_r;
    logic [31:0] last_lc;
    logic [31:0] last_rc;
    logic [31:0] total_l;
    logic [31:0] total_r;
    int          ramp_l;
    int          ramp_r;
    longint      err_l;
    longint      err_r;

    control_t pending_controls[$];
    int       mismatches;
    int       idle_pct;
    int       tgt_l;
    int       tgt_r;
    int       hold_l;
    int       hold_r;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int ramp_next(input int cur, input int tgt);
        int a;
        int d;
        int v;
        a = accel_q;
        d = decel_q;
        v = cur;
        if (v < tgt && v >= 0)
        begin
            v = v + a;
            if (v > tgt)
                v = tgt;
        end
        else if (v > tgt && v > 0)
        begin
            v = v - d;
            if (v < tgt)
                v = tgt;
        end
        else if (v < tgt && v < 0)
        begin
            v = v + d;
            if (v > tgt)
                v = tgt;
        end
        else if (v > tgt && tgt <= 0)
        begin
            v = v - a;
            if (v < tgt)
                v = tgt;
        end
        return v;
    endfunction

    // the prior error always equals the error left by the previous tick
    function automatic longint wheel_drive(inout longint err, input int speed,
                                           input longint delta,
                                           input logic [15:0] kp, input logic [15:0] kd);
        longint e;
        longint kpv;
        longint kdv;
        longint d;
        kpv = kp;
        kdv = kd;
        e = clip(err + speed - delta, ERR_MIN, ERR_MAX);
        d = kpv * e + kdv * (e - err);
        err = e;
        return clip(d, DRIVE_MIN, DRIVE_MAX);
    endfunction

    task automatic reset_controller();
        accel_q = dwrpd_pkg::ACCEL_STEP_RST;
        decel_q = dwrpd_pkg::DECEL_STEP_RST;
        kp_l    = dwrpd_pkg::PROP_GAIN_RST;
        kd_l    = dwrpd_pkg::DERIV_GAIN_RST;
        kp_r    = dwrpd_pkg::PROP_GAIN_RST;
        kd_r    = dwrpd_pkg::DERIV_GAIN_RST;
        last_lc = '0;
        last_rc = '0;
        total_l = '0;
        total_r = '0;
        ramp_l  = 0;
        ramp_r  = 0;
        err_l   = 0;
        err_r   = 0;
    endtask

    task automatic update_controller(input tick_t t);
        logic [31:0] dl_raw;
        logic [31:0] dr_raw;
        longint      dl;
        longint      dr;
        longint      sum;
        control_t    c;
        dl_raw  = t.left_counter - last_lc;
        dr_raw  = t.right_counter - last_rc;
        dl      = longint'($signed(dl_raw));
        dr      = longint'($signed(dr_raw));
        last_lc = t.left_counter;
        last_rc = t.right_counter;
        total_l = total_l + dl_raw;
        total_r = total_r + dr_raw;
        sum     = longint'($signed(total_l)) + longint'($signed(total_r));
        ramp_l  = ramp_next(ramp_l, t.target_left);
        ramp_r  = ramp_next(ramp_r, t.target_right);
        c.drive_left  = 16'(wheel_drive(err_l, ramp_l, dl, kp_l, kd_l));
        c.drive_right = 16'(wheel_drive(err_r, ramp_r, dr, kp_r, kd_r));
        c.speed_left  = 16'(ramp_l);
        c.speed_right = 16'(ramp_r);
        c.distance    = 32'(sum / 2);
        pending_controls.push_back(c);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic check_control();
        control_t want;
        if (pending_controls.size() == 0)
        begin
            report("unexpected result beat", 0, 0);
            return;
        end
        want = pending_controls.pop_front();
        if (result_bus.drive_left !== want.drive_left)
            report("drive_left", result_bus.drive_left, want.drive_left);
        if (result_bus.drive_right !== want.drive_right)
            report("drive_right", result_bus.drive_right, want.drive_right);
        if (result_bus.speed_left !== want.speed_left)
            report("speed_left", result_bus.speed_left, want.speed_left);
        if (result_bus.speed_right !== want.speed_right)
            report("speed_right", result_bus.speed_right, want.speed_right);
        if (result_bus.distance !== want.distance)
            report("distance", result_bus.distance, want.distance);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            check_control();
    end

    always @(negedge clk)
    begin
        result_bus.ready = ($urandom_range(0, 99) >= idle_pct);
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_tick(input tick_t t);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            tick_bus.valid = 1'b0;
            @(negedge clk);
        end
        tick_bus.valid         = 1'b1;
        tick_bus.left_counter  = t.left_counter;
        tick_bus.right_counter = t.right_counter;
        tick_bus.target_left   = t.target_left;
        tick_bus.target_right  = t.target_right;
        @(posedge clk);
        while (tick_bus.ready !== 1'b1)
            @(posedge clk);
        update_controller(t);
        @(negedge clk);
    endtask

    task automatic step_by(input logic [31:0] dl, input logic [31:0] dr,
                           input logic signed [15:0] tl, input logic signed [15:0] tr);
        tick_t t;
        t.left_counter  = last_lc + dl;
        t.right_counter = last_rc + dr;
        t.target_left   = tl;
        t.target_right  = tr;
        send_tick(t);
    endtask

    task automatic wait_results();
        tick_bus.valid = 1'b0;
        while (pending_controls.size() != 0)
            @(negedge clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dwrpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dwrpd_pkg::CFG_DATA_W-1:0] data);
        tick_bus.valid = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            dwrpd_pkg::CFG_ACCEL_STEP:       accel_q = data[7:0];
            dwrpd_pkg::CFG_DECEL_STEP:       decel_q = data[7:0];
            dwrpd_pkg::CFG_PROP_GAIN_LEFT:   kp_l = data;
            dwrpd_pkg::CFG_DERIV_GAIN_LEFT:  kd_l = data;
            dwrpd_pkg::CFG_PROP_GAIN_RIGHT:  kp_r = data;
            dwrpd_pkg::CFG_DERIV_GAIN_RIGHT: kd_r = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] next_counter(input logic [31:0] last, input int speed,
                                                 input longint err);
        int          pick;
        logic [31:0] d;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            d = 32'(speed + int'($urandom_range(0, 8)) - 4);
        else if (pick < 85)
            d = 32'(int'($urandom_range(0, 131072)) - 65536);
        else if (pick < 92)
            return $urandom();
        else if (pick < 97)
            d = 32'(err + speed);
        else
            d = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return last + d;
    endfunction

    function automatic int pick_target();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return int'($urandom_range(0, 4000)) - 2000;
        if (pick < 75)
            return int'($urandom_range(0, 600)) - 300;
        return int'($signed(16'($urandom())));
    endfunction

    task automatic send_random_tick();
        tick_t t;
        if (hold_l == 0)
        begin
            tgt_l  = pick_target();
            hold_l = $urandom_range(1, 40);
        end
        if (hold_r == 0)
        begin
            tgt_r  = pick_target();
            hold_r = $urandom_range(1, 40);
        end
        hold_l--;
        hold_r--;
        t.left_counter  = next_counter(last_lc, ramp_l, err_l);
        t.right_counter = next_counter(last_rc, ramp_r, err_r);
        t.target_left   = 16'(tgt_l);
        t.target_right  = 16'(tgt_r);
        send_tick(t);
    endtask

    function automatic logic [15:0] rand_gain();
        if ($urandom_range(0, 1))
            return 16'($urandom_range(0, 64));
        return 16'($urandom());
    endfunction

    task automatic test_defaults();
        repeat (4) step_by(32'd1, 32'hFFFF_FFFF, 16'sd10, -16'sd10);
    endtask

    // slow down through zero, speed up in reverse, then slow back to a stop
    task automatic test_ramp_branches();
        drain();
        write_reg(dwrpd_pkg::CFG_ACCEL_STEP, 16'd40);
        write_reg(dwrpd_pkg::CFG_DECEL_STEP, 16'd25);
        repeat (4) step_by(32'd0, 32'd0, -16'sd60, 16'sd60);
        repeat (3) step_by(32'd5, -32'sd5, 16'sd0, 16'sd0);
    endtask

    // zero steps hold the speed; upper data bits land outside the step registers
    task automatic test_zero_step();
        drain();
        write_reg(dwrpd_pkg::CFG_ACCEL_STEP, 16'hFF00);
        write_reg(dwrpd_pkg::CFG_DECEL_STEP, 16'hFF00);
        repeat (2) step_by(32'd7, 32'd7, 16'sd32767, -16'sd32768);
    endtask

    // counter wrap, total wrap, error and drive saturation
    task automatic test_wraparound();
        tick_t t;
        drain();
        write_reg(dwrpd_pkg::CFG_ACCEL_STEP, 16'h00FF);
        write_reg(dwrpd_pkg::CFG_DECEL_STEP, 16'h00FF);
        repeat (3) step_by(32'h7FFF_FFFF, 32'h8000_0000, 16'sd100, -16'sd100);
        t.left_counter  = 32'hFFFF_FFFF;
        t.right_counter = 32'h0000_0000;
        t.target_left   = -16'sd32768;
        t.target_right  = 16'sd32767;
        send_tick(t);
        step_by(32'd2, 32'hFFFF_FFFE, -16'sd32768, 16'sd32767);
    endtask

    // widest and zero gains; spare register indexes must change nothing
    task automatic test_gain_extremes();
        drain();
        write_reg(dwrpd_pkg::CFG_PROP_GAIN_LEFT, 16'hFFFF);
        write_reg(dwrpd_pkg::CFG_DERIV_GAIN_LEFT, 16'hFFFF);
        write_reg(dwrpd_pkg::CFG_PROP_GAIN_RIGHT, 16'h0000);
        write_reg(dwrpd_pkg::CFG_DERIV_GAIN_RIGHT, 16'h0000);
        write_reg(CFG_SPARE_6, 16'hFFFF);
        write_reg(CFG_SPARE_7, 16'h0001);
        repeat (2) step_by(32'd3, -32'sd3, 16'sd50, -16'sd50);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            if (phase == 0)
            begin
                write_reg(dwrpd_pkg::CFG_ACCEL_STEP, 16'h00FF);
                write_reg(dwrpd_pkg::CFG_DECEL_STEP, 16'h00FF);
                write_reg(dwrpd_pkg::CFG_PROP_GAIN_LEFT, 16'hFFFF);
                write_reg(dwrpd_pkg::CFG_DERIV_GAIN_LEFT, 16'hFFFF);
                write_reg(dwrpd_pkg::CFG_PROP_GAIN_RIGHT, 16'hFFFF);
                write_reg(dwrpd_pkg::CFG_DERIV_GAIN_RIGHT, 16'hFFFF);
            end
            else if (phase == 1)
            begin
                write_reg(dwrpd_pkg::CFG_ACCEL_STEP, {8'($urandom()), 8'h00});
                write_reg(dwrpd_pkg::CFG_DECEL_STEP, {8'($urandom()), 8'h00});
                write_reg(dwrpd_pkg::CFG_PROP_GAIN_LEFT, 16'h0000);
                write_reg(dwrpd_pkg::CFG_DERIV_GAIN_LEFT, 16'h0000);
                write_reg(dwrpd_pkg::CFG_PROP_GAIN_RIGHT, 16'h0000);
                write_reg(dwrpd_pkg::CFG_DERIV_GAIN_RIGHT, 16'h0000);
            end
            else
            begin
                write_reg(dwrpd_pkg::CFG_ACCEL_STEP,
                          {8'($urandom()), 8'($urandom_range(1, 255))});
                write_reg(dwrpd_pkg::CFG_DECEL_STEP,
                          {8'($urandom()), 8'($urandom_range(1, 255))});
                write_reg(dwrpd_pkg::CFG_PROP_GAIN_LEFT, rand_gain());
                write_reg(dwrpd_pkg::CFG_DERIV_GAIN_LEFT, rand_gain());
                write_reg(dwrpd_pkg::CFG_PROP_GAIN_RIGHT, rand_gain());
                write_reg(dwrpd_pkg::CFG_DERIV_GAIN_RIGHT, rand_gain());
            end
            // no idling on either side for one whole phase
            idle_pct = (phase == 2) ? 0 : 11;
            for (int i = 0; i < 80; i++)
            begin
                if (phase == 4 && i == 40)
                    wait_results();
                send_random_tick();
            end
        end
        idle_pct = 11;
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        tick_bus.valid         = 1'b0;
        tick_bus.left_counter  = '0;
        tick_bus.right_counter = '0;
        tick_bus.target_left   = '0;
        tick_bus.target_right  = '0;
        result_bus.ready       = 1'b0;
        mismatches             = 0;
        idle_pct               = 11;
        tgt_l                  = 0;
        tgt_r                  = 0;
        hold_l                 = 0;
        hold_r                 = 0;
        reset_controller();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_defaults();
        test_ramp_branches();
        test_zero_step();
        test_wraparound();
        test_gain_extremes();
        test_random_phases();

        wait_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
